// ===== rtl/core/ils_pkg.sv =====
// ils_pkg: command and status codes plus the array control struct
// shared by the decode, entry array and top level of the list store
// no dependencies
package ils_pkg;

  // request commands
  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // control for one update of the entry array
  typedef struct packed {
    logic do_write;
    logic shift_up;
    logic shift_down;
  } array_op_t;

  // fixed field widths
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 5;

endpackage

// ===== rtl/core/ils_decode.sv =====
// ils_decode: command decode, range and full checks, next count
// depends on ils_pkg
module ils_decode #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned CW = $clog2(CAPACITY + 1),
  parameter int unsigned PW = (CW > 5) ? CW : 5
) (
  input  logic [1:0]               cmd,
  input  logic [4:0]               position,
  input  logic [CW-1:0]            count,
  output ils_pkg::array_op_t       op,
  output logic [PW-1:0]            idx,
  output logic [CW-1:0]            count_next,
  output ils_pkg::status_t         status,
  output logic                     read_ok
);
  import ils_pkg::*;

  logic [PW-1:0] pos_ext;
  logic [PW-1:0] count_ext;
  logic          full;

  assign pos_ext   = PW'(position);
  assign count_ext = PW'(count);
  assign full      = (count >= CW'(CAPACITY));

  // per-command checks and array control
  always_comb begin
    op         = '0;
    idx        = pos_ext;
    count_next = count;
    status     = ST_OK;
    read_ok    = 1'b0;
    case (cmd_t'(cmd))
      CMD_APPEND: begin
        idx = count_ext;
        if (full) begin
          status = ST_FULL;
        end else begin
          op.do_write = 1'b1;
          count_next  = count + CW'(1);
        end
      end
      CMD_INSERT: begin
        if (pos_ext > count_ext) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          op.do_write = 1'b1;
          op.shift_up = 1'b1;
          count_next  = count + CW'(1);
        end
      end
      CMD_REMOVE: begin
        if (pos_ext >= count_ext) begin
          status = ST_RANGE;
        end else begin
          op.shift_down = 1'b1;
          count_next    = count - CW'(1);
        end
      end
      CMD_READ: begin
        if (pos_ext >= count_ext) begin
          status = ST_RANGE;
        end else begin
          read_ok = 1'b1;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

endmodule

// ===== rtl/core/ils_entry_array.sv =====
// ils_entry_array: row of entry registers with per-entry shift muxes
// and a read mux over the positions a request can address
// depends on ils_pkg
module ils_entry_array #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned PW = 5
) (
  input  logic                     clk,
  input  logic                     en,
  input  ils_pkg::array_op_t       op,
  input  logic [PW-1:0]            idx,
  input  logic signed [31:0]       value,
  output logic signed [31:0]       rd_value
);
  import ils_pkg::*;

  localparam int unsigned RD_N = (CAPACITY < 32) ? CAPACITY : 32;

  logic signed [VALUE_W-1:0] entries [CAPACITY];

  // each entry takes the input value, its lower or its upper neighbor, or holds its own value
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (op.do_write && PW'(i) == idx) begin
          entries[i] <= value;
        end else if (op.do_write && op.shift_up && PW'(i) > idx && i > 0) begin
          entries[i] <= entries[(i > 0) ? i - 1 : 0];
        end else if (op.shift_down && PW'(i) >= idx && i + 1 < CAPACITY) begin
          entries[i] <= entries[(i + 1 < CAPACITY) ? i + 1 : i];
        end
      end
    end
  end

  // read mux, only the positions a 5-bit index reaches
  always_comb begin
    rd_value = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (PW'(i) == idx) begin
        rd_value = entries[i];
      end
    end
  end

endmodule

// ===== rtl/core/indexed_list_store_core.sv =====
// indexed_list_store_core: ordered list of signed 32-bit values with
// append, insert, remove and read at a position
// the input transfer loads the input register; decode, entry update
// and the result register load follow once the output is free
// (out_valid low or out_ready high); throughput: one request per
// cycle while the output is not stalled, as all entries shift at
// once through per-entry muxes; reset clears the count and the
// valid flags, entries hold no defined value until written
module indexed_list_store_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic [4:0]         position,
  input  logic signed [31:0] item_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] read_value,
  output logic [4:0]         item_count,
  output logic [1:0]         status
);
  import ils_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > 5) ? CW : 5;

  // input register
  logic               s1_valid;
  logic [1:0]         s1_cmd;
  logic [4:0]         s1_pos;
  logic signed [31:0] s1_value;
  logic               s1_advance;

  // list state and decode results
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  array_op_t          op;
  logic [PW-1:0]      idx;
  status_t            st;
  logic               read_ok;
  logic signed [31:0] rd_value;
  logic [PW-1:0]      count_ext;

  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  // input stage capture
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd   <= cmd;
      s1_pos   <= position;
      s1_value <= item_value;
    end
  end

  ils_decode #(
    .CAPACITY (CAPACITY),
    .CW       (CW),
    .PW       (PW)
  ) u_decode (
    .cmd        (s1_cmd),
    .position   (s1_pos),
    .count      (count),
    .op         (op),
    .idx        (idx),
    .count_next (count_next),
    .status     (st),
    .read_ok    (read_ok)
  );

  ils_entry_array #(
    .CAPACITY (CAPACITY),
    .PW       (PW)
  ) u_array (
    .clk      (clk),
    .en       (s1_advance),
    .op       (op),
    .idx      (idx),
    .value    (s1_value),
    .rd_value (rd_value)
  );

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (s1_advance) begin
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign count_ext = PW'(count_next);

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      read_value <= read_ok ? rd_value : 32'sd0;
      item_count <= count_ext[4:0];
      status     <= st;
    end
  end

endmodule

// ===== bench/testbench.sv =====
// testbench: self-checking bench for indexed_list_store_core with a random
// valid/ready driver and monitor and a cycle-free model of the list contents
// depends on ils_pkg and indexed_list_store_core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ils_pkg::*;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned RANDOM_ITEMS = 1550;

  typedef struct {
    cmd_t               op;
    logic [4:0]         pos;
    logic signed [31:0] value;
    int unsigned        gap;
  } list_request_t;

  typedef struct {
    logic signed [31:0] read_value;
    logic [4:0]         item_count;
    status_t            status;
  } list_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         cmd = CMD_APPEND;
  logic [4:0]         position = '0;
  logic signed [31:0] item_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] read_value;
  logic [4:0]         item_count;
  logic [1:0]         status;

  // requests waiting to be driven and results waiting to be seen
  list_request_t pending_requests[$];
  list_result_t  expected_results[$];

  // list contents as the block should hold them
  logic signed [31:0] shadow_list [CAPACITY];
  int unsigned        shadow_len = 0;

  // list length as seen by the stimulus plan
  int unsigned plan_len = 0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  int          tx_wait = -1;
  int          rx_wait = 0;
  int unsigned failures = 0;

  indexed_list_store_core #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .position  (position),
    .item_value(item_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_value(read_value),
    .item_count(item_count),
    .status    (status)
  );

  // clock
  always #6 clk = ~clk;

  // single reset at the start of the run
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  task automatic report_mismatch(input string msg);
    failures++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // apply one accepted request to the list and queue its result
  task automatic apply_list_request(input logic [1:0] op, input logic [4:0] pos,
                                    input logic signed [31:0] value);
    list_result_t res;
    res.read_value = '0;
    res.status = ST_OK;
    case (cmd_t'(op))
      CMD_APPEND: begin
        if (shadow_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          shadow_list[shadow_len] = value;
          shadow_len++;
        end
      end
      CMD_INSERT: begin
        if (pos > shadow_len) begin
          res.status = ST_RANGE;
        end else if (shadow_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          // open a slot at pos by moving the tail up one entry
          for (int i = CAPACITY - 1; i > 0; i--) begin
            if (i > pos && i <= shadow_len) shadow_list[i] = shadow_list[i - 1];
          end
          shadow_list[pos] = value;
          shadow_len++;
        end
      end
      CMD_REMOVE: begin
        if (pos >= shadow_len) begin
          res.status = ST_RANGE;
        end else begin
          // close the gap at pos by moving the tail down one entry
          for (int i = 0; i < CAPACITY - 1; i++) begin
            if (i >= pos && i + 1 < shadow_len) shadow_list[i] = shadow_list[i + 1];
          end
          shadow_len--;
        end
      end
      default: begin
        if (pos >= shadow_len) res.status = ST_RANGE;
        else res.read_value = shadow_list[pos];
      end
    endcase
    res.item_count = shadow_len[4:0];
    expected_results.insert(expected_results.size(), res);
  endtask

  // value mix: extremes now and then, otherwise any 32-bit pattern
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 11))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sh0000_0000;
      3: return 32'shffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // position inside the current list, or zero on an empty one
  function automatic int held_pos();
    return (plan_len == 0) ? 0 : $urandom_range(0, plan_len - 1);
  endfunction

  task automatic queue_request(input cmd_t op, input int pos, input logic signed [31:0] value);
    list_request_t req;
    req.op = op;
    req.pos = pos[4:0];
    req.value = value;
    req.gap = tx_burst ? 0 : $urandom_range(0, 3);
    pending_requests.insert(pending_requests.size(), req);
    // keep the plan's length in step so positions can aim inside the list
    case (op)
      CMD_APPEND: if (plan_len < CAPACITY) plan_len++;
      CMD_INSERT: if (pos <= plan_len && plan_len < CAPACITY) plan_len++;
      CMD_REMOVE: if (pos < plan_len) plan_len--;
      default: ;
    endcase
  endtask

  // stimulus plan and end of run
  initial begin
    int roll;
    bit growing;
    growing = 1'b1;

    // directed: empty list, edges of position and value, full list
    queue_request(CMD_READ, 0, 0);
    queue_request(CMD_REMOVE, 0, 0);
    queue_request(CMD_INSERT, 1, 7);
    queue_request(CMD_INSERT, 0, 32'sh8000_0000);
    queue_request(CMD_APPEND, 31, 32'sh7fff_ffff);
    queue_request(CMD_INSERT, 3, -1);
    queue_request(CMD_READ, 31, 0);
    queue_request(CMD_REMOVE, 31, 0);
    queue_request(CMD_INSERT, 31, 5);
    while (plan_len < CAPACITY) queue_request(CMD_APPEND, 0, pick_value());
    queue_request(CMD_APPEND, 0, 1);
    queue_request(CMD_INSERT, CAPACITY, 2);
    queue_request(CMD_INSERT, CAPACITY + 1, 3);
    queue_request(CMD_READ, CAPACITY - 1, 0);
    queue_request(CMD_REMOVE, CAPACITY - 1, 0);
    queue_request(CMD_REMOVE, 0, 0);
    queue_request(CMD_READ, 7, 0);

    // random: grow and shrink sweeps with a little noise
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll = $urandom_range(0, 99);
      if (plan_len == CAPACITY && $urandom_range(0, 3) == 0) growing = 1'b0;
      else if (plan_len == 0 && $urandom_range(0, 2) == 0) growing = 1'b1;
      if ($urandom_range(0, 149) == 0) tx_burst = !tx_burst;
      if (roll < 8) begin
        queue_request(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 31), pick_value());
      end else if (growing) begin
        if (roll < 50) queue_request(CMD_APPEND, $urandom_range(0, 31), pick_value());
        else if (roll < 78) queue_request(CMD_INSERT, $urandom_range(0, plan_len), pick_value());
        else if (roll < 90) queue_request(CMD_READ, held_pos(), pick_value());
        else queue_request(CMD_REMOVE, held_pos(), pick_value());
      end else begin
        if (roll < 60) queue_request(CMD_REMOVE, held_pos(), pick_value());
        else if (roll < 85) queue_request(CMD_READ, held_pos(), pick_value());
        else if (roll < 93) queue_request(CMD_APPEND, $urandom_range(0, 31), pick_value());
        else queue_request(CMD_INSERT, $urandom_range(0, plan_len), pick_value());
      end
    end

    // drain, checked between edges once the driver and monitor have settled
    @(negedge rst);
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_wait = -1;
    end else if (in_valid && !in_ready) begin
      // hold the request until transfer
    end else begin
      if (in_valid) apply_list_request(cmd, position, item_value);
      if (pending_requests.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        if (tx_wait < 0) tx_wait = pending_requests[0].gap;
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else begin
          cmd        <= pending_requests[0].op;
          position   <= pending_requests[0].pos;
          item_value <= pending_requests[0].value;
          in_valid   <= 1'b1;
          void'(pending_requests.pop_front());
          tx_wait = -1;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if ($urandom_range(0, 299) == 0) rx_burst = !rx_burst;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: value %0d count %0d status %0d",
                                    read_value, item_count, status));
        end else begin
          want = expected_results.pop_front();
          if (read_value !== want.read_value)
            report_mismatch($sformatf("read_value got %0d expected %0d",
                                      read_value, want.read_value));
          if (item_count !== want.item_count)
            report_mismatch($sformatf("item_count got %0d expected %0d",
                                      item_count, want.item_count));
          if (status !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d", status, want.status));
        end
        rx_wait = rx_burst ? 0 : $urandom_range(0, 3);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_ready <= (rx_wait == 0);
    end
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== indexed_list_store_core.f =====
rtl/core/ils_pkg.sv
rtl/core/ils_decode.sv
rtl/core/ils_entry_array.sv
rtl/core/indexed_list_store_core.sv
bench/testbench.sv
